// File: rtl/core/tlb_fill_round_robin_defines.svh
// ----------------------------------------------------------------------------
// tlb_fill_round_robin_defines
// Assertion macros used by the translation buffer fill sequencer; each macro
// expects signals named clk and rst in the using module.
// ----------------------------------------------------------------------------
`ifndef TLB_FILL_ROUND_ROBIN_DEFINES_SVH
`define TLB_FILL_ROUND_ROBIN_DEFINES_SVH
`ifndef SYNTH
`define TFRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfrr assertion failed");
`define TFRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfrr assertion failed");
`else
`define TFRR_ASSERT_IMPL(lbl, ante, cons)
`define TFRR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/tfrr_pkg.sv
// ----------------------------------------------------------------------------
// tfrr_pkg
// Types and constants for the translation buffer fill block.
// ----------------------------------------------------------------------------
package tfrr_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int PAGE_W          = 20;
  localparam int SLOT_W          = 6;
  localparam int MODE_W          = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INVALIDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH      = 2'd2;

  typedef struct packed {
    logic [PAGE_W-1:0] virtual_page;
    logic [PAGE_W-1:0] physical_page;
    logic              dirty;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_INVALIDATE
  } state_t;

endpackage

// File: rtl/core/tfrr_ram.sv
// ----------------------------------------------------------------------------
// tfrr_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tfrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/tfrr_seq.sv
// ----------------------------------------------------------------------------
// tfrr_seq
// Sequencer: valid bits, replacement pointer and slot scans over the RAM.
// ----------------------------------------------------------------------------
`include "tlb_fill_round_robin_defines.svh"

module tfrr_seq #(
  parameter int ENTRIES = tfrr_pkg::ENTRIES_DEFAULT,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tfrr_pkg::MODE_W-1:0] mode,
  input  logic [tfrr_pkg::PAGE_W-1:0] virtual_page,
  input  logic [tfrr_pkg::PAGE_W-1:0] physical_page,
  input  logic                        writable,
  output logic                        done,
  output logic [tfrr_pkg::SLOT_W-1:0] slot,
  output logic                        took_free,
  output logic                        found,
  output logic                        ram_we,
  output logic [IDX_W-1:0]            ram_addr,
  output tfrr_pkg::entry_t            ram_wdata,
  input  tfrr_pkg::entry_t            ram_rdata
);

  import tfrr_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_t            state, state_next;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  idx;
  logic              rd_live;
  logic              cmp_live;
  logic [IDX_W-1:0]  cmp_idx;
  entry_t            req;

  logic              accept;
  logic              ins_free, ins_evict, inv_hit, inv_miss;
  logic              done_next;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign ins_free  = (state == S_INSERT) && !valid[idx];
  assign ins_evict = (state == S_INSERT) && valid[idx] && (idx == LAST);
  assign inv_hit   = (state == S_INVALIDATE) && cmp_live && valid[cmp_idx] &&
                     (ram_rdata.virtual_page == req.virtual_page);
  assign inv_miss  = (state == S_INVALIDATE) && cmp_live && !inv_hit &&
                     (cmp_idx == LAST);
  assign done_next = (accept && mode != MODE_INSERT && mode != MODE_INVALIDATE) ||
                     ins_free || ins_evict || inv_hit || inv_miss;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = req;
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_INSERT) begin
          state_next = S_INSERT;
        end else if (accept && mode == MODE_INVALIDATE) begin
          state_next = S_INVALIDATE;
        end
      end
      S_INSERT: begin
        if (ins_free) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end else if (ins_evict) begin
          ram_we     = 1'b1;
          ram_addr   = ptr;
          state_next = S_IDLE;
        end
      end
      S_INVALIDATE: begin
        if (inv_hit || inv_miss) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counters, valid bits, pointer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      ptr      <= '0;
      done     <= 1'b0;
      rd_live  <= 1'b0;
      cmp_live <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= '0;
            rd_live  <= 1'b1;
            cmp_live <= 1'b0;
            req      <= '{virtual_page: virtual_page, physical_page: physical_page,
                          dirty: writable};
            if (mode != MODE_INSERT && mode != MODE_INVALIDATE) begin
              slot      <= '0;
              took_free <= 1'b0;
              found     <= 1'b0;
            end
            if (mode == MODE_FLUSH) begin
              valid <= '0;
            end
          end
        end
        S_INSERT: begin
          if (ins_free) begin
            valid[idx] <= 1'b1;
            slot       <= SLOT_W'(idx);
            took_free  <= 1'b1;
            found      <= 1'b0;
          end else if (ins_evict) begin
            valid[ptr] <= 1'b1;
            ptr        <= (ptr == LAST) ? '0 : ptr + 1'b1;
            slot       <= SLOT_W'(ptr);
            took_free  <= 1'b0;
            found      <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_INVALIDATE: begin
          if (inv_hit) begin
            valid[cmp_idx] <= 1'b0;
            slot           <= SLOT_W'(cmp_idx);
            took_free      <= 1'b0;
            found          <= 1'b1;
          end else if (inv_miss) begin
            slot           <= '0;
            took_free      <= 1'b0;
            found          <= 1'b0;
          end else begin
            // Read issued at idx returns next cycle for comparison.
            cmp_live <= rd_live;
            cmp_idx  <= idx;
            rd_live  <= rd_live && (idx != LAST);
            if (idx != LAST) begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `TFRR_ASSERT_NEXT(a_accept_progress, accept, busy || done)
  `TFRR_ASSERT_IMPL(a_ptr_evict_only, !$stable(ptr), $past(ins_evict) || $past(rst))
  `TFRR_ASSERT_IMPL(a_found_from_scan, done && found, !took_free && $past(state == S_INVALIDATE))

endmodule

// File: rtl/core/tlb_fill_round_robin.sv
// ----------------------------------------------------------------------------
// tlb_fill_round_robin
// Translation buffer fill with free-slot-first, round-robin replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode and the page fields; the command transfers at the
//   edge where start is high and busy is low. Modes: insert, invalidate by
//   virtual page, flush. Any other mode code does nothing and returns zeros.
//   Each command returns one result on slot, took_free and found, marked
//   by done for exactly one cycle; the receiver cannot stall it.
// Completion:
//   flush and unused codes: done is registered straight from the transfer.
//   insert: takes the lowest free slot from a scan of the valid bits; when
//     full, evicts at the pointer, which then advances.
//   invalidate: clears the lowest valid slot whose virtual page matches.
//   Scans walk one slot per cycle from slot 0, the invalidate scan through
//   the single entry RAM port; one command is in flight at a time. A new
//   command may transfer in the cycle done is shown.
// Reset (synchronous, active high) clears every valid bit and the pointer
// at once; entry RAM contents are only read behind a valid bit.
// ----------------------------------------------------------------------------
module tlb_fill_round_robin #(
  parameter int ENTRIES = tfrr_pkg::ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tfrr_pkg::MODE_W-1:0] mode,
  input  logic [tfrr_pkg::PAGE_W-1:0] virtual_page,
  input  logic [tfrr_pkg::PAGE_W-1:0] physical_page,
  input  logic                        writable,
  output logic                        done,
  output logic [tfrr_pkg::SLOT_W-1:0] slot,
  output logic                        took_free,
  output logic                        found
);

  import tfrr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // Entry RAM port, driven by the sequencer.
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Hold valid bits and pointer; scan slots; drive the result strobe.
  tfrr_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .virtual_page   (virtual_page),
    .physical_page  (physical_page),
    .writable       (writable),
    .done           (done),
    .slot           (slot),
    .took_free      (took_free),
    .found          (found),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata)
  );

  // Store virtual page, physical page and dirty bit per slot.
  tfrr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata_raw)
  );

endmodule

// File: sim/tb_tlb_fill_round_robin.sv
// ----------------------------------------------------------------------------
// tb_tlb_fill_round_robin
// Self-checking bench for the translation buffer fill block. A scoreboard
// class keeps its own copy of the slot table and the replacement pointer,
// predicts each command's outcome and checks every done strobe against it.
// Directed commands cover the corner cases. Long random runs then fill the
// table, evict, invalidate and flush.
// ----------------------------------------------------------------------------
module tb_tlb_fill_round_robin;
  import tfrr_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  // No command is defined for the top mode code; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_COMMANDS = 1450;
  localparam int CYCLE_LIMIT = 1000000;

  // One predicted outcome per transferred command.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              took_free;
    logic              found;
  } outcome_t;

  // Shadow of the slot table. Predicts outcomes and checks them in order.
  class fill_checker;
    bit                valid [ENTRIES];
    logic [PAGE_W-1:0] vpage [ENTRIES];
    logic [PAGE_W-1:0] ppage [ENTRIES];
    bit                dirty [ENTRIES];
    int unsigned       pointer;
    outcome_t          pending_outcomes [$];
    int mismatches, inserts, evictions, hits, misses, flushes, unused;

    function new();
      for (int i = 0; i < ENTRIES; i++) valid[i] = 0;
      pointer = 0;
    endfunction

    function void note_command(logic [MODE_W-1:0] m, logic [PAGE_W-1:0] vp,
                               logic [PAGE_W-1:0] pp, logic wr);
      outcome_t o;
      int       target;
      bit       placed;
      o = '0;
      target = 0;
      placed = 0;
      case (m)
        MODE_INSERT: begin
          for (int i = 0; i < ENTRIES; i++)
            if (!valid[i] && !placed) begin
              target = i;
              placed = 1;
            end
          if (!placed) begin
            target = pointer % ENTRIES;
            pointer = (target + 1) % ENTRIES;
            evictions++;
          end
          valid[target] = 1;
          vpage[target] = vp;
          ppage[target] = pp;
          dirty[target] = wr;
          o.slot = target[SLOT_W-1:0];
          o.took_free = placed;
          inserts++;
        end
        MODE_INVALIDATE: begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && vpage[i] == vp && !placed) begin
              target = i;
              placed = 1;
            end
          if (placed) begin
            valid[target] = 0;
            o.slot = target[SLOT_W-1:0];
            o.found = 1;
            hits++;
          end else begin
            misses++;
          end
        end
        MODE_FLUSH: begin
          for (int i = 0; i < ENTRIES; i++) valid[i] = 0;
          flushes++;
        end
        default: begin
          unused++;
        end
      endcase
      pending_outcomes.push_back(o);
    endfunction

    task report_mismatch(string what, logic [SLOT_W-1:0] got, logic [SLOT_W-1:0] want);
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_outcome(logic [SLOT_W-1:0] s, logic u, logic f);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", s, '0);
      end else begin
        o = pending_outcomes.pop_front();
        if (s !== o.slot) report_mismatch("slot", s, o.slot);
        if (u !== o.took_free) report_mismatch("took_free", u, o.took_free);
        if (f !== o.found) report_mismatch("found", f, o.found);
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode;
  logic [PAGE_W-1:0] virtual_page;
  logic [PAGE_W-1:0] physical_page;
  logic              writable;
  logic              done;
  logic [SLOT_W-1:0] slot;
  logic              took_free;
  logic              found;

  fill_checker       ledger;
  logic [PAGE_W-1:0] page_pool [12];
  int                cycles;

  tlb_fill_round_robin #(.ENTRIES(ENTRIES)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .virtual_page   (virtual_page),
    .physical_page  (physical_page),
    .writable       (writable),
    .done           (done),
    .slot           (slot),
    .took_free      (took_free),
    .found          (found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hang: end the run if the cycle count runs away.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_tlb_fill_round_robin NOT OK");
      $finish;
    end
  end

  // Results cannot be held off: check every strobe as it passes.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) ledger.check_outcome(slot, took_free, found);
  end

  // Drop start while idling; scramble the payload so that any sampling
  // outside a transfer shows up.
  task idle(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      virtual_page <= PAGE_W'($urandom);
      physical_page <= PAGE_W'($urandom);
    end
  endtask

  // Present one command and hold it until the transfer edge.
  task send_command(logic [MODE_W-1:0] m, logic [PAGE_W-1:0] vp,
                    logic [PAGE_W-1:0] pp, logic wr);
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    virtual_page <= vp;
    physical_page <= pp;
    writable <= wr;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.note_command(m, vp, pp, wr);
  endtask

  task wait_for_drain();
    while (ledger.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Pick from a small pool at times so that duplicate mappings build up.
  function logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(0, 99) < 30) return page_pool[$urandom_range(0, 11)];
    return PAGE_W'($urandom);
  endfunction

  // Return the page of some valid slot, or a random page if none is valid.
  function logic [PAGE_W-1:0] pick_live_page();
    int first;
    int idx;
    first = $urandom_range(0, ENTRIES - 1);
    for (int i = 0; i < ENTRIES; i++) begin
      idx = (first + i) % ENTRIES;
      if (ledger.valid[idx]) return ledger.vpage[idx];
    end
    return pick_page();
  endfunction

  initial begin
    int roll;
    bit quiet;
    ledger = new();
    cycles = 0;
    for (int i = 0; i < 12; i++) page_pool[i] = PAGE_W'($urandom);
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_INSERT;
    virtual_page = '0;
    physical_page = '0;
    writable = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unused code, miss and flush on an empty table, field extremes,
    // duplicates, repeated invalidates down to a miss, refill after a flush.
    send_command(MODE_UNUSED, 20'hFFFFF, 20'hFFFFF, 1'b1);
    send_command(MODE_INVALIDATE, 20'h00000, 20'h00000, 1'b0);
    send_command(MODE_FLUSH, 20'hFFFFF, 20'hFFFFF, 1'b1);
    send_command(MODE_INSERT, 20'h00000, 20'hFFFFF, 1'b1);
    send_command(MODE_INSERT, 20'hFFFFF, 20'h00000, 1'b0);
    send_command(MODE_INSERT, 20'h00000, 20'h55555, 1'b0);
    send_command(MODE_INSERT, 20'hAAAAA, 20'hAAAAA, 1'b1);
    send_command(MODE_INVALIDATE, 20'h00000, 20'hFFFFF, 1'b1);
    send_command(MODE_INVALIDATE, 20'h00000, 20'h00000, 1'b0);
    send_command(MODE_INVALIDATE, 20'h00000, 20'h00000, 1'b0);
    send_command(MODE_INSERT, 20'h12345, 20'h6789A, 1'b1);
    send_command(MODE_INVALIDATE, 20'hFFFFF, 20'h00000, 1'b0);
    send_command(MODE_UNUSED, 20'hAAAAA, 20'h00000, 1'b0);
    send_command(MODE_INVALIDATE, 20'hAAAAA, 20'h00000, 1'b0);
    send_command(MODE_FLUSH, 20'h00000, 20'h00000, 1'b0);
    send_command(MODE_INVALIDATE, 20'h12345, 20'h00000, 1'b0);
    send_command(MODE_INSERT, 20'h55555, 20'hFFFFF, 1'b1);
    send_command(MODE_INSERT, 20'hFFFFF, 20'hFFFFF, 1'b1);

    // Random: mostly inserts so the table fills and evicts, invalidates that
    // mostly hit, rare flushes so full stretches last.
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      // Hold off once mid-run until the block has answered everything.
      if (n == RANDOM_COMMANDS / 2) begin
        idle(1);
        wait_for_drain();
      end
      quiet = (n >= 300 && n < 520);
      if (!quiet && $urandom_range(0, 99) < 34)
        idle(($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3));
      roll = $urandom_range(0, 999);
      if (roll < 650)
        send_command(MODE_INSERT, pick_page(), PAGE_W'($urandom),
                     1'($urandom_range(0, 1)));
      else if (roll < 980)
        send_command(MODE_INVALIDATE,
                     ($urandom_range(0, 99) < 70) ? pick_live_page() : pick_page(),
                     PAGE_W'($urandom), 1'($urandom_range(0, 1)));
      else if (roll < 985)
        send_command(MODE_FLUSH, PAGE_W'($urandom), PAGE_W'($urandom),
                     1'($urandom_range(0, 1)));
      else
        send_command(MODE_UNUSED, PAGE_W'($urandom), PAGE_W'($urandom),
                     1'($urandom_range(0, 1)));
    end

    idle(1);
    wait_for_drain();
    // Allow a late stray strobe to surface.
    repeat (ENTRIES + 8) @(posedge clk);

    $display("run: %0d inserts (%0d evictions), %0d invalidate hits, %0d misses",
             ledger.inserts, ledger.evictions, ledger.hits, ledger.misses);
    $display("run: %0d flushes, %0d unused codes, %0d mismatches",
             ledger.flushes, ledger.unused, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("tb_tlb_fill_round_robin OK");
    end else begin
      $display("tb_tlb_fill_round_robin NOT OK");
    end
    $finish;
  end

endmodule
